[rtl/atns_pkg.sv]
// Shared types and constants for the tone/noise/crowd sound block.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package atns_pkg;

   // Request codes carried in req_type
   localparam logic [2:0] REQ_NOTE_DIV     = 3'd0;
   localparam logic [2:0] REQ_NOISE_RST    = 3'd1;
   localparam logic [2:0] REQ_CROWD_BOUNCE = 3'd2;
   localparam logic [2:0] REQ_TONE_TICK    = 3'd3;
   localparam logic [2:0] REQ_NOISE_TICK   = 3'd4;

   // DAC levels and divider constants
   localparam logic [7:0] LEVEL_ON     = 8'hFF;
   localparam logic [7:0] LEVEL_OFF    = 8'h00;
   localparam logic [7:0] DIV_STOP     = 8'hFF;
   localparam logic [8:0] TONE_RELOAD  = 9'd256;

   // One input item
   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data_byte;
   } atns_req_type;

   // One result item
   typedef struct packed {
      logic [7:0] tone_level;
      logic [7:0] bounce_level;
      logic [7:0] crowd_level;
   } atns_rsp_type;

endpackage

[rtl/atns_req_stage.sv]
// Input register of the sound block: captures one request transfer.
// Depends on atns_pkg.
`timescale 1ns / 1ps

module atns_req_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  atns_pkg::atns_req_type req_data,
   output logic                 item_valid,
   output atns_pkg::atns_req_type item_data,
   input  logic                 item_take
);
   import atns_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   atns_req_type data_ff;
   logic         accept;

   // Hold off the sender only while a captured item cannot move on
   assign req_stall = valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on each accepted transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

[rtl/atns_engine.sv]
// Sound state and single-pass update: tone divider, noise shift pair, crowd/bounce.
// Depends on atns_pkg.
`timescale 1ns / 1ps

module atns_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_take,
   input  atns_pkg::atns_req_type item_data,
   output atns_pkg::atns_rsp_type result
);
   import atns_pkg::*;

   logic [7:0] divider_ff,   divider_in;
   logic [8:0] tone_cnt_ff,  tone_cnt_in;
   logic       tone_idle_ff, tone_idle_in;
   logic [7:0] shift_b_ff,   shift_b_in;
   logic [7:0] shift_a_ff,   shift_a_in;
   logic       noise_bit_ff, noise_bit_in;
   logic       noise_en_ff,  noise_en_in;
   logic [3:0] amp_ff,       amp_in;
   logic [7:0] tone_out_ff,  tone_out_in;
   logic [7:0] bounce_ff,    bounce_in;
   logic [7:0] crowd_ff,     crowd_in;

   logic [8:0] cnt_dec;
   logic [8:0] cnt_step;
   logic [8:0] half_span;
   logic [8:0] mid_point;
   logic       b_new;

   // Tone divider arithmetic
   assign cnt_dec   = tone_cnt_ff - 9'd1;
   assign cnt_step  = (cnt_dec == {1'b0, divider_ff}) ? TONE_RELOAD : cnt_dec;
   assign half_span = (TONE_RELOAD - {1'b0, divider_ff}) >> 1;
   assign mid_point = half_span + {1'b0, divider_ff};

   // Noise feedback bit
   assign b_new = shift_b_ff[0] ^ ~shift_a_ff[6];

   // Next state for the item in the input register
   always_comb begin
      divider_in   = divider_ff;
      tone_cnt_in  = tone_cnt_ff;
      tone_idle_in = tone_idle_ff;
      shift_b_in   = shift_b_ff;
      shift_a_in   = shift_a_ff;
      noise_bit_in = noise_bit_ff;
      noise_en_in  = noise_en_ff;
      amp_in       = amp_ff;
      tone_out_in  = tone_out_ff;
      bounce_in    = bounce_ff;
      crowd_in     = crowd_ff;
      unique case (item_data.req_type)
         REQ_NOTE_DIV: begin
            divider_in  = item_data.data_byte;
            tone_cnt_in = TONE_RELOAD;
            if (item_data.data_byte != DIV_STOP) begin
               tone_idle_in = 1'b0;
            end
         end
         REQ_NOISE_RST: begin
            shift_b_in  = '0;
            shift_a_in  = '0;
            crowd_in    = LEVEL_OFF;
            noise_en_in = 1'b1;
         end
         REQ_CROWD_BOUNCE: begin
            amp_in    = item_data.data_byte[3:0];
            crowd_in  = noise_bit_ff ? {item_data.data_byte[3:0], 4'b0000} : LEVEL_OFF;
            bounce_in = item_data.data_byte[4] ? LEVEL_ON : LEVEL_OFF;
         end
         REQ_TONE_TICK: begin
            if (!tone_idle_ff) begin
               tone_cnt_in = cnt_step;
               tone_out_in = (cnt_step > mid_point) ? LEVEL_ON : LEVEL_OFF;
               if (divider_ff == DIV_STOP) begin
                  tone_idle_in = 1'b1;
               end
            end
         end
         REQ_NOISE_TICK: begin
            if (noise_en_ff) begin
               shift_b_in   = {shift_b_ff[6:0], b_new};
               shift_a_in   = {shift_a_ff[6:0], shift_b_ff[7]};
               noise_bit_in = shift_a_ff[6];
               crowd_in     = shift_a_ff[6] ? {amp_ff, 4'b0000} : LEVEL_OFF;
            end
         end
         default: begin
         end
      endcase
   end

   // Advance state when the item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= DIV_STOP;
         tone_cnt_ff  <= TONE_RELOAD;
         tone_idle_ff <= 1'b1;
         shift_b_ff   <= '0;
         shift_a_ff   <= '0;
         noise_bit_ff <= 1'b0;
         noise_en_ff  <= 1'b0;
         amp_ff       <= '0;
         tone_out_ff  <= LEVEL_OFF;
         bounce_ff    <= LEVEL_OFF;
         crowd_ff     <= LEVEL_OFF;
      end else if (item_take) begin
         divider_ff   <= divider_in;
         tone_cnt_ff  <= tone_cnt_in;
         tone_idle_ff <= tone_idle_in;
         shift_b_ff   <= shift_b_in;
         shift_a_ff   <= shift_a_in;
         noise_bit_ff <= noise_bit_in;
         noise_en_ff  <= noise_en_in;
         amp_ff       <= amp_in;
         tone_out_ff  <= tone_out_in;
         bounce_ff    <= bounce_in;
         crowd_ff     <= crowd_in;
      end
   end

   assign result.tone_level   = tone_out_in;
   assign result.bounce_level = bounce_in;
   assign result.crowd_level  = crowd_in;

   // Counter stays above the divider and never passes the reload value
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (tone_cnt_ff > {1'b0, divider_ff}) && (tone_cnt_ff <= TONE_RELOAD))
      else $error("tone counter out of range");

   // Tone DAC is a pure square wave
   a_tone_level: assert property (@(posedge clock) disable iff (reset)
      (tone_out_ff == LEVEL_OFF) || (tone_out_ff == LEVEL_ON))
      else $error("tone level not 0 or 255");

   // Crowd level is silent whenever the noise bit is low
   a_crowd_gate: assert property (@(posedge clock) disable iff (reset)
      !noise_bit_ff |-> (crowd_ff == LEVEL_OFF))
      else $error("crowd level on while noise bit low");

   // A noise tick while disabled leaves the shift pair alone
   a_noise_hold: assert property (@(posedge clock) disable iff (reset)
      (item_take && !noise_en_ff && (item_data.req_type == REQ_NOISE_TICK))
      |=> ($stable(shift_a_ff) && $stable(shift_b_ff)))
      else $error("noise registers moved while disabled");

endmodule

[rtl/atns_rsp_stage.sv]
// Result register of the sound block: holds one result until transferred.
// Depends on atns_pkg.
`timescale 1ns / 1ps

module atns_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_take,
   input  atns_pkg::atns_rsp_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output atns_pkg::atns_rsp_type rsp_data
);
   import atns_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   atns_rsp_type data_ff;

   // Take a new item unless a result is held up by the receiver
   assign item_take = item_valid && !(valid_ff && rsp_stall);
   assign valid_in  = item_take || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/arcade_tone_noise_sound_block_top.sv]
// A request is captured in the input register, then in the result register.
// Throughput: one item per cycle while rsp_stall is low; the two registers
// decouple the sides, so one item is buffered while a result is stalled.
// Every item gives exactly one result holding the three DAC levels.
// Reset (synchronous, active high) empties both registers and restores the
// idle tone, cleared noise and silent DAC state.
`timescale 1ns / 1ps

module arcade_tone_noise_sound_block_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  atns_pkg::atns_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output atns_pkg::atns_rsp_type rsp_data
);
   import atns_pkg::*;

   logic         item_valid;
   logic         item_take;
   atns_req_type item_data;
   atns_rsp_type result;

   // Capture request transfers
   atns_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_take  (item_take)
   );

   // Update sound state
   atns_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .item_take (item_take),
      .item_data (item_data),
      .result    (result)
   );

   // Hold results for the receiver
   atns_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // A captured item that cannot move on blocks new requests
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !item_take) |-> req_stall)
      else $error("request accepted while input register blocked");

   // An item moving on always produces a result next cycle
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      item_take |=> rsp_valid)
      else $error("item taken without result");

endmodule
